>>> hdl/skdu_pkg.sv
// Shared types and constants for the serial key-state debouncer.
package skdu_pkg;

  // Defaults for the top-level parameters
  localparam int LINE_BYTES_DEF   = 32;
  localparam int ELAPSED_BITS_DEF = 16;

  // Input selector (s_axis_tuser)
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Output kind (m_axis_tuser)
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_SYNC = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_ONLY = 2'd2;
  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RESET = 16'd50;

  // Characters of a text line
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_END   = 8'h00;
  localparam logic [7:0] RAW_HI_MASK = 8'hF0;

  // Result of the line parser for the byte currently presented
  typedef struct packed {
    logic       ok;      // newline closes a valid line
    logic [3:0] nibble;  // low four bits of the line value
  } line_out_t;

endpackage

>>> hdl/skdu_line.sv
// Decimal text line parser: collects bytes up to newline into a 32-bit value.
module skdu_line
  import skdu_pkg::*;
#(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  logic [7:0] rx_byte,
  output line_out_t line_out
);

  localparam int LW = $clog2(LINE_BYTES);
  localparam logic [LW-1:0] LEN_MAX = LW'(LINE_BYTES - 1);

  logic [LW-1:0] len;
  logic [31:0]   value;
  logic          seen;
  logic          bad;
  logic          ended;

  logic          full;
  logic          is_digit;
  logic [3:0]    digit;
  logic [35:0]   nv;

  assign full     = (len >= LEN_MAX);
  assign is_digit = (rx_byte >= CHAR_0) && (rx_byte <= CHAR_9);
  assign digit    = 4'(rx_byte - CHAR_0);
  // value * 10 + digit
  assign nv = {1'b0, value, 3'b000} + {3'b000, value, 1'b0} + {32'd0, digit};

  assign line_out.ok     = !full && (rx_byte == CHAR_NL) && !bad && seen;
  assign line_out.nibble = value[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      len   <= '0;
      value <= '0;
      seen  <= 1'b0;
      bad   <= 1'b0;
      ended <= 1'b0;
    end else if (step) begin
      if (full || rx_byte == CHAR_NL) begin
        len   <= '0;
        value <= '0;
        seen  <= 1'b0;
        bad   <= 1'b0;
        ended <= 1'b0;
      end else begin
        len <= len + 1'b1;
        if (!ended) begin
          if (rx_byte == CHAR_END) begin
            ended <= 1'b1;
          end else if (rx_byte == CHAR_PLUS && len == '0) begin
            // leading sign
          end else if (is_digit) begin
            seen <= 1'b1;
            if (|nv[35:32]) begin
              bad <= 1'b1;
            end else begin
              value <= nv[31:0];
            end
          end else begin
            bad <= 1'b1;
          end
        end
      end
    end
  end

endmodule

>>> hdl/serial_key_state_debouncer_unit.sv
// Serial key-state receiver with per-button debounce (top level).
//
// Each transaction on the input carries either a received byte or a 1 ms
// tick (s_axis_tuser). Items pass an input register and are processed into
// an 8-slot result register, which the output drains one result per cycle
// while m_axis_tready is high. A tick, or a byte that yields no result, is
// taken every cycle, even while results drain. A byte that yields results
// (1 to 8 of them) waits until the result register is empty or giving up
// its last result. Configuration is written through cfg_we/cfg_index/cfg_data.
module serial_key_state_debouncer_unit
  import skdu_pkg::*;
#(
  parameter int LINE_BYTES   = LINE_BYTES_DEF,
  parameter int ELAPSED_BITS = ELAPSED_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // [7:0] rx_byte
  input  logic                  s_axis_tuser,  // [0] operation
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,  // [1:0] key_code, [2] key_pressed
  output logic                  m_axis_tuser,  // [0] event_kind
  output logic                  m_axis_tlast,  // last_of_run
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = (ELAPSED_BITS > CFG_DATA_W) ? ELAPSED_BITS : CFG_DATA_W;
  localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;
  localparam logic [2:0] SLOT_POWER_SYNC = 3'd6;
  localparam logic [2:0] SLOT_FINAL      = 3'd7;

  // configuration
  logic [CFG_DATA_W-1:0] debounce_ticks;
  logic                  raw_mode;
  logic                  press_only_sync;

  // input register
  logic       in_valid;
  logic       in_op;
  logic [7:0] in_byte;

  // block state
  logic [3:0]              stored_buttons;
  logic [ELAPSED_BITS-1:0] elapsed [4];

  // result register
  logic [7:0] mask;
  logic [2:0] pressed;

  line_out_t  line_out;
  logic       byte_item;
  logic       st_valid;
  logic [3:0] state;
  logic [3:0] acc;
  logic [7:0] new_mask;
  logic [7:0] mask_after;
  logic [2:0] sel;
  logic       take;
  logic       fire;
  logic       line_step;
  logic [3:0] pressed_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks  <= DEBOUNCE_RESET;
      raw_mode        <= 1'b0;
      press_only_sync <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE:   debounce_ticks  <= cfg_data;
        CFG_RAW_MODE:   raw_mode        <= cfg_data[0];
        CFG_PRESS_ONLY: press_only_sync <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op   <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
  end

  skdu_line #(
    .LINE_BYTES(LINE_BYTES)
  ) u_line (
    .clk     (clk),
    .rst     (rst),
    .step    (line_step),
    .rx_byte (in_byte),
    .line_out(line_out)
  );

  assign byte_item = (in_op == OP_BYTE);
  assign st_valid  = byte_item && (raw_mode ? ((in_byte & RAW_HI_MASK) == 8'h00)
                                            : line_out.ok);
  assign state     = raw_mode ? in_byte[3:0] : line_out.nibble;
  assign line_step = fire && byte_item && !raw_mode;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      acc[b] = st_valid && (state[b] != stored_buttons[b]) &&
               (CW'(elapsed[b]) > CW'(debounce_ticks));
    end
    // slots: key b at 2b, release sync of b at 2b+1, power release sync, final sync
    new_mask = '0;
    for (int b = 0; b < 3; b++) begin
      new_mask[2*b]   = acc[b];
      new_mask[2*b+1] = acc[b] && press_only_sync && !state[b];
    end
    new_mask[SLOT_POWER_SYNC] = acc[3] && press_only_sync && !state[3];
    new_mask[SLOT_FINAL]      = |acc;
  end

  // lowest pending slot goes out first
  always_comb begin
    sel = SLOT_FINAL;
    for (int i = 7; i >= 0; i--) begin
      if (mask[i]) sel = 3'(i);
    end
  end

  assign take        = m_axis_tvalid && m_axis_tready;
  assign mask_after  = take ? (mask & ~(8'b1 << sel)) : mask;
  assign fire        = in_valid && ((new_mask == '0) || (mask_after == '0));
  assign pressed_ext = {1'b0, pressed};

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else begin
      mask <= mask_after | (fire ? new_mask : 8'h00);
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (new_mask != '0)) begin
      pressed <= state[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_buttons <= '0;
      for (int b = 0; b < 4; b++) elapsed[b] <= '0;
    end else if (fire) begin
      if (!byte_item) begin
        for (int b = 0; b < 4; b++) begin
          if (elapsed[b] != ELAPSED_MAX) elapsed[b] <= elapsed[b] + 1'b1;
        end
      end else begin
        for (int b = 0; b < 4; b++) begin
          if (acc[b]) elapsed[b] <= '0;
        end
        if (|acc) stored_buttons <= state;
      end
    end
  end

  always_comb begin
    m_axis_tvalid = |mask;
    m_axis_tlast  = (sel == SLOT_FINAL);
    if (!sel[0] && sel < SLOT_POWER_SYNC) begin
      m_axis_tuser = KIND_KEY;
      m_axis_tdata = {5'b00000, pressed_ext[sel[2:1]], sel[2:1]};
    end else begin
      m_axis_tuser = KIND_SYNC;
      m_axis_tdata = 8'h00;
    end
  end

endmodule

>>> hdl/skdu_checker.sv
// Port-level checks for the serial key-state debouncer, bound to the top level.
module skdu_checker
  import skdu_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result pending right after reset");

  // every run closes with a sync, never with a key report
  a_key_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_KEY |-> !m_axis_tlast &&
      m_axis_tdata[1:0] != 2'd3 && m_axis_tdata[7:3] == 5'd0)
    else $error("bad key report");

  a_sync_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_SYNC |-> m_axis_tdata == 8'h00)
    else $error("sync marker carries data");

endmodule

bind serial_key_state_debouncer_unit skdu_checker u_skdu_checker (
  .clk          (clk),
  .rst          (rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

>>> tb/testbench.sv
// Self-checking testbench for the serial key-state debouncer unit.
module testbench;
  import skdu_pkg::*;

  localparam int LINE_MAX = LINE_BYTES_DEF - 1;
  localparam int BTN_POWER = 3;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 20;
  localparam int RUN_LIMIT = 1_500_000 * 12;
  localparam logic [1:0] SYNC_CODE = 2'd0;

  typedef struct packed {
    logic       kind;
    logic [1:0] code;
    logic       pressed;
    logic       last;
  } key_event_t;

  class key_scoreboard;
    logic [CFG_DATA_W-1:0]       debounce;
    logic                        raw;
    logic                        press_sync;
    logic [3:0]                  buttons;
    logic [ELAPSED_BITS_DEF-1:0] elapsed [4];
    int unsigned                 line_len;
    logic [31:0]                 line_val;
    logic                        digit_seen;
    logic                        line_bad;
    logic                        line_ended;
    key_event_t                  events_q[$];
    int                          errors;

    function new();
      debounce = DEBOUNCE_RESET;
      raw = 1'b0;
      press_sync = 1'b0;
      buttons = '0;
      foreach (elapsed[b]) elapsed[b] = '0;
      restart_line();
      errors = 0;
    endfunction

    function void restart_line();
      line_len = 0;
      line_val = '0;
      digit_seen = 1'b0;
      line_bad = 1'b0;
      line_ended = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_DEBOUNCE: debounce = val;
        CFG_RAW_MODE: raw = val[0];
        CFG_PRESS_ONLY: press_sync = val[0];
        default: ;
      endcase
    endfunction

    function void push_event(logic kind, logic [1:0] code, logic pressed);
      key_event_t ev;
      ev = '{kind: kind, code: code, pressed: pressed, last: 1'b0};
      events_q.push_back(ev);
    endfunction

    // Debounce a new button state; buttons are walked up, down, select, power.
    function void apply_state(logic [3:0] st);
      logic [3:0] changed;
      bit         accepted;
      int         first;
      key_event_t ev;
      first = events_q.size();
      changed = st ^ buttons;
      accepted = 0;
      for (int b = 0; b < 4; b++) begin
        if (changed[b] && elapsed[b] > debounce) begin
          elapsed[b] = '0;
          accepted = 1;
          if (b != BTN_POWER) push_event(KIND_KEY, 2'(b), st[b]);
          if (press_sync && !st[b]) push_event(KIND_SYNC, SYNC_CODE, 1'b0);
        end
      end
      if (accepted) begin
        push_event(KIND_SYNC, SYNC_CODE, 1'b0);
        buttons = st;
      end
      if (events_q.size() > first) begin
        ev = events_q.pop_back();
        ev.last = 1'b1;
        events_q.push_back(ev);
      end
    endfunction

    function void note_input(logic op, logic [7:0] data);
      logic [63:0] nxt;
      logic        ok;
      logic [3:0]  nib;
      if (op == OP_TICK) begin
        foreach (elapsed[b]) if (elapsed[b] != '1) elapsed[b]++;
        return;
      end
      if (raw) begin
        if ((data & RAW_HI_MASK) == 8'h00) apply_state(data[3:0]);
        return;
      end
      // full line: the byte is dropped and the line starts over
      if (line_len >= LINE_MAX) begin
        restart_line();
        return;
      end
      line_len++;
      if (data == CHAR_NL) begin
        ok = !line_bad && digit_seen;
        nib = line_val[3:0];
        restart_line();
        if (ok) apply_state(nib);
        return;
      end
      if (line_ended) return;
      if (data == CHAR_END) begin
        line_ended = 1'b1;
      end else if (data >= CHAR_0 && data <= CHAR_9) begin
        nxt = 64'(line_val) * 10 + 64'(data - CHAR_0);
        digit_seen = 1'b1;
        if (nxt > 64'hFFFF_FFFF) line_bad = 1'b1;
        else line_val = nxt[31:0];
      end else if (data != CHAR_PLUS || line_len != 1) begin
        line_bad = 1'b1;
      end
    endfunction

    function void check_result(key_event_t got);
      key_event_t want;
      if (events_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: kind=%0d code=%0d pressed=%0d last=%0d",
                   got.kind, got.code, got.pressed, got.last);
        return;
      end
      want = events_q.pop_front();
      if (got.kind !== want.kind || got.code !== want.code ||
          got.pressed !== want.pressed || got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected kind=%0d code=%0d pressed=%0d last=%0d, %s",
                   want.kind, want.code, want.pressed, want.last,
                   $sformatf("got kind=%0d code=%0d pressed=%0d last=%0d",
                             got.kind, got.code, got.pressed, got.last));
      end
    endfunction

    function int outstanding();
      return events_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;  // [7:0] rx_byte
  logic                  s_axis_tuser = 1'b0;  // [0] operation
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;  // [1:0] key_code, [2] key_pressed
  logic                  m_axis_tuser;  // [0] event_kind
  logic                  m_axis_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  key_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;

  serial_key_state_debouncer_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    m_axis_tready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // inputs are noted before outputs are checked at the same edge
  always @(posedge clk) begin : monitor
    key_event_t seen;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        seen = '{kind: m_axis_tuser, code: m_axis_tdata[1:0],
                 pressed: m_axis_tdata[2], last: m_axis_tlast};
        sb.check_result(seen);
      end
    end
  end

  // called at a falling edge, returns at a falling edge with tvalid left high
  task automatic send_item(logic op, logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= data;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(OP_TICK, 8'($urandom()));
  endtask

  task automatic send_line(string txt);
    for (int i = 0; i < txt.len(); i++) send_item(OP_BYTE, txt[i]);
    send_item(OP_BYTE, CHAR_NL);
  endtask

  task automatic send_random_line();
    string       txt;
    logic [7:0]  q[$];
    int          kind;
    int          pos;
    kind = $urandom_range(9);
    txt = $sformatf("%0d", $urandom_range(15));
    if ($urandom_range(1)) txt = {"0", txt};
    if ($urandom_range(1)) txt = {"+", txt};
    case (kind)
      6: txt = $sformatf("%0d", $urandom());
      7: txt = $sformatf("%0d%0d", $urandom() | 32'h8000_0000, $urandom_range(9));
      8: txt = ($urandom_range(1)) ? "" : "+";
      default: ;
    endcase
    for (int i = 0; i < txt.len(); i++) q.push_back(txt[i]);
    case (kind)
      4: begin
        // text stops at a zero byte; the rest is not parsed
        q.push_back(CHAR_END);
        repeat ($urandom_range(3)) q.push_back(8'($urandom()));
      end
      5: begin
        pos = $urandom_range(q.size());
        q.insert(pos, 8'($urandom()));
      end
      9: repeat ($urandom_range(34, 28)) q.push_back(8'(CHAR_0 + $urandom_range(9)));
      default: ;
    endcase
    q.push_back(CHAR_NL);
    foreach (q[i]) send_item(OP_BYTE, q[i]);
  endtask

  // wait for every expected result, then for the input register to empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, logic [CFG_DATA_W-1:0] deb,
                           logic raw, logic press, int n_items);
    int target;
    int r;
    settle();
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_RAW_MODE, {15'd0, raw});
    write_reg(CFG_PRESS_ONLY, {15'd0, press});
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    target = items_sent + n_items;
    while (items_sent < target) begin
      r = $urandom_range(99);
      if (r < 25) send_ticks($urandom_range(3, 1));
      else if (sb.raw && r < 85) send_item(OP_BYTE, 8'($urandom_range(15)));
      else if (sb.raw || r >= 90) send_item(OP_BYTE, 8'($urandom_range(255)));
      else send_random_line();
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset configuration: text lines, 50 ms debounce
    send_ticks(51);
    send_line("+5");
    send_line("");
    send_line("+");
    send_line("1+2");
    send_line("4294967296");
    send_line("4294967295");

    // short debounce keeps the tick runs brief from here on
    settle();
    write_reg(CFG_DEBOUNCE, 16'd2);
    send_ticks(3);
    send_item(OP_BYTE, "1");
    send_item(OP_BYTE, "0");
    send_item(OP_BYTE, CHAR_END);
    send_item(OP_BYTE, "x");
    send_item(OP_BYTE, CHAR_NL);
    // 31 stored bytes fill the line; the newline after them is dropped
    repeat (LINE_MAX) send_item(OP_BYTE, "1");
    send_item(OP_BYTE, CHAR_NL);
    send_line("3");
    // partial line survives a trip through raw mode
    send_item(OP_BYTE, CHAR_PLUS);
    send_item(OP_BYTE, "1");
    settle();
    write_reg(CFG_PRESS_ONLY, 16'd1);
    write_reg(CFG_RAW_MODE, 16'd1);
    send_ticks(3);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hF0);
    settle();
    write_reg(CFG_RAW_MODE, 16'd0);
    send_ticks(3);
    send_item(OP_BYTE, "2");
    send_item(OP_BYTE, CHAR_NL);

    run_phase(0, 0, 16'd0, 1'b0, 1'b1, 30);
    run_phase(65, 0, 16'd2, 1'b1, 1'b0, 30);
    run_phase(0, 65, 16'd1, 1'b0, 1'b0, 30);
    run_phase(8, 8, 16'($urandom_range(4)), 1'($urandom_range(1)),
              1'($urandom_range(1)), 30);

    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("Mismatches found");
    $finish;
  end

endmodule
